### sv/cursor_sequence_store_assert.svh
// Assertion macros shared by the cursor sequence store modules.
`ifndef CURSOR_SEQUENCE_STORE_ASSERT_SVH
`define CURSOR_SEQUENCE_STORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every rising edge outside reset.
`define CSS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define CSS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CSS_ASSERT_IMP(lbl, ante, cons, msg)
`define CSS_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

### sv/csstore_pkg.sv
// Shared types and codes of the cursor sequence store.
package csstore_pkg;

    // Request codes carried in a request word.
    typedef enum logic [3:0] {
        REQ_START        = 4'd0,
        REQ_END          = 4'd1,
        REQ_LAST         = 4'd2,
        REQ_ADVANCE      = 4'd3,
        REQ_RETREAT      = 4'd4,
        REQ_INSERT       = 4'd5,
        REQ_ATTACH       = 4'd6,
        REQ_REMOVE       = 4'd7,
        REQ_INSERT_FRONT = 4'd8,
        REQ_APPEND       = 4'd9,
        REQ_REMOVE_FRONT = 4'd10,
        REQ_READ_INDEX   = 4'd11,
        REQ_READ_CURRENT = 4'd12
    } req_t;

    // Status codes returned in a response word.
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_NO_CURRENT = 2'd2,
        ST_RANGE      = 2'd3
    } status_t;

    // Memory operations carried out by the sequencer.
    typedef enum logic [1:0] {
        SEQ_NONE = 2'd0,
        SEQ_UP   = 2'd1,
        SEQ_DOWN = 2'd2,
        SEQ_READ = 2'd3
    } seq_op_t;

    // Command from the request decoder to the sequencer.
    typedef struct packed {
        logic    go;
        seq_op_t op;
        logic    shift;
    } seq_ctl_t;

    // Status from the sequencer back to the request decoder.
    typedef struct packed {
        logic busy;
        logic done;
    } seq_sts_t;

endpackage

### sv/cursor_sequence_store.sv
// Top level of the cursor sequence store: request decoder, count and cursor, response register.
//
// An ordered store of up to CAPACITY_WORDS words with an entry count and a cursor.
// Requests arrive on the req channel (req_valid, req_stall, req_type, entry_value,
// read_position) and each yields exactly one word on the rsp channel (rsp_valid,
// rsp_stall, read_value, status_code, entry_count, cursor_position, on_entry).
// A word is taken at a rising edge with valid high and stall low.
// One request is worked on at a time; req_stall is high from acceptance until the
// response is loaded into the output register.
// Cursor moves and failed requests do not touch the entry memory. Insertions and
// removals move the entries behind the point one place a cycle through the single
// write port of the entry memory, each entry written in the cycle after it is read.
// A new request is accepted while the previous response still waits in the output
// register; if the receiver holds rsp_stall, the finished response waits and
// further requests stall.
// Reset clears the count, the cursor and all handshake state; the entry memory is
// not cleared, as only entries below the count are ever read.
`include "cursor_sequence_store_assert.svh"

module cursor_sequence_store #(
    parameter int CAPACITY_WORDS = 32,
    parameter int WORD_BITS      = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [3:0]         req_type,
    input  logic signed [31:0] entry_value,
    input  logic [4:0]         read_position,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic signed [31:0] read_value,
    output logic [1:0]         status_code,
    output logic [5:0]         entry_count,
    output logic [5:0]         cursor_position,
    output logic               on_entry
);

    import csstore_pkg::*;

    localparam int AW = $clog2(CAPACITY_WORDS);
    localparam int CW = $clog2(CAPACITY_WORDS + 1);

    typedef enum logic [2:0] {
        T_IDLE = 3'b001,
        T_WORK = 3'b010,
        T_DONE = 3'b100
    } top_state_t;

    top_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] cursor_reg, cursor_next;
    status_t st_pend_reg, st_pend_next;
    logic signed [31:0] rd_pend_reg, rd_pend_next;
    logic is_read_reg, is_read_next;
    logic rsp_valid_reg, rsp_valid_next;
    logic signed [31:0] read_value_reg, read_value_next;
    status_t status_reg, status_next;
    logic [5:0] count_out_reg, count_out_next;
    logic [5:0] cursor_out_reg, cursor_out_next;
    logic on_entry_reg, on_entry_next;

    logic accept;
    logic on_cur;
    logic full;
    logic [CW-1:0] count_dec;
    logic [CW-1:0] cursor_inc;
    logic [CW-1:0] pos_inc;
    status_t dec_status;
    logic [CW-1:0] dec_count;
    logic [CW-1:0] dec_cursor;
    seq_op_t dec_op;
    logic [CW-1:0] seq_pos;
    logic [AW-1:0] read_addr;
    logic signed [WORD_BITS-1:0] word_ext;

    seq_ctl_t seq_ctl;
    seq_sts_t seq_sts;
    logic [AW-1:0] seq_first;
    logic [AW-1:0] seq_end;
    logic [AW-1:0] seq_prev;
    logic [AW-1:0] seq_put;
    logic signed [WORD_BITS-1:0] seq_rdata;

    assign accept     = req_valid && (state_reg == T_IDLE);
    assign on_cur     = (cursor_reg < count_reg);
    assign full       = (count_reg >= CW'(CAPACITY_WORDS));
    assign count_dec  = count_reg - CW'(1);
    assign cursor_inc = cursor_reg + CW'(1);
    assign pos_inc    = seq_pos + CW'(1);
    assign word_ext   = WORD_BITS'(entry_value);
    assign read_addr  = AW'(read_position);

    // Request decode: new count, cursor and status, and the memory work to launch.
    always_comb
    begin
        dec_status = ST_OK;
        dec_count  = count_reg;
        dec_cursor = cursor_reg;
        dec_op     = SEQ_NONE;
        seq_pos    = cursor_reg;
        case (req_t'(req_type))
            REQ_START:
            begin
                dec_cursor = '0;
            end
            REQ_END:
            begin
                dec_cursor = (count_reg != '0) ? count_dec : '0;
            end
            REQ_LAST:
            begin
                dec_cursor = CW'(CAPACITY_WORDS - 1);
            end
            REQ_ADVANCE:
            begin
                if (!on_cur)
                begin
                    dec_status = ST_NO_CURRENT;
                end
                else
                begin
                    dec_cursor = cursor_inc;
                end
            end
            REQ_RETREAT:
            begin
                if (cursor_reg != '0)
                begin
                    dec_cursor = cursor_reg - CW'(1);
                end
            end
            REQ_INSERT:
            begin
                if (full)
                begin
                    dec_status = ST_FULL;
                end
                else
                begin
                    seq_pos    = on_cur ? cursor_reg : '0;
                    dec_cursor = seq_pos;
                    dec_count  = count_reg + CW'(1);
                    dec_op     = SEQ_UP;
                end
            end
            REQ_ATTACH:
            begin
                if (full)
                begin
                    dec_status = ST_FULL;
                end
                else
                begin
                    if (on_cur)
                    begin
                        seq_pos    = cursor_inc;
                        dec_cursor = cursor_inc;
                    end
                    else
                    begin
                        seq_pos = count_reg;
                    end
                    dec_count = count_reg + CW'(1);
                    dec_op    = SEQ_UP;
                end
            end
            REQ_REMOVE:
            begin
                if (!on_cur)
                begin
                    dec_status = ST_NO_CURRENT;
                end
                else
                begin
                    seq_pos   = cursor_reg;
                    dec_count = count_dec;
                    dec_op    = SEQ_DOWN;
                end
            end
            REQ_INSERT_FRONT:
            begin
                if (full)
                begin
                    dec_status = ST_FULL;
                end
                else
                begin
                    seq_pos    = '0;
                    dec_cursor = '0;
                    dec_count  = count_reg + CW'(1);
                    dec_op     = SEQ_UP;
                end
            end
            REQ_APPEND:
            begin
                if (full)
                begin
                    dec_status = ST_FULL;
                end
                else
                begin
                    seq_pos   = count_reg;
                    dec_count = count_reg + CW'(1);
                    dec_op    = SEQ_UP;
                end
            end
            REQ_REMOVE_FRONT:
            begin
                if (!on_cur)
                begin
                    dec_status = ST_NO_CURRENT;
                end
                else
                begin
                    seq_pos   = '0;
                    dec_count = count_dec;
                    dec_op    = SEQ_DOWN;
                end
            end
            REQ_READ_INDEX:
            begin
                if (32'(read_position) >= 32'(count_reg))
                begin
                    dec_status = ST_RANGE;
                end
                else
                begin
                    dec_op = SEQ_READ;
                end
            end
            REQ_READ_CURRENT:
            begin
                if (!on_cur)
                begin
                    dec_status = ST_NO_CURRENT;
                end
                else
                begin
                    dec_op = SEQ_READ;
                end
            end
            default:
            begin
                dec_status = ST_OK;
            end
        endcase
    end

    // Addresses for the sequencer. An upward shift reads from the top entry down to the
    // insertion point; a downward shift reads from just above the removal point upwards.
    always_comb
    begin
        seq_first = AW'(count_dec);
        seq_end   = AW'(seq_pos);
        seq_prev  = AW'(count_reg);
        seq_put   = AW'(seq_pos);
        seq_ctl.shift = 1'b0;
        case (dec_op)
            SEQ_UP:
            begin
                seq_ctl.shift = (count_reg > seq_pos);
            end
            SEQ_DOWN:
            begin
                seq_first     = AW'(pos_inc);
                seq_end       = AW'(count_dec);
                seq_prev      = AW'(seq_pos);
                seq_ctl.shift = (count_reg > pos_inc);
            end
            SEQ_READ:
            begin
                seq_first = (req_t'(req_type) == REQ_READ_INDEX) ? read_addr : AW'(cursor_reg);
            end
            default:
            begin
                seq_ctl.shift = 1'b0;
            end
        endcase
        seq_ctl.go = accept && (dec_op != SEQ_NONE);
        seq_ctl.op = dec_op;
    end

    // Request flow and the response register.
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        cursor_next     = cursor_reg;
        st_pend_next    = st_pend_reg;
        rd_pend_next    = rd_pend_reg;
        is_read_next    = is_read_reg;
        rsp_valid_next  = rsp_valid_reg;
        read_value_next = read_value_reg;
        status_next     = status_reg;
        count_out_next  = count_out_reg;
        cursor_out_next = cursor_out_reg;
        on_entry_next   = on_entry_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    count_next   = dec_count;
                    cursor_next  = dec_cursor;
                    st_pend_next = dec_status;
                    rd_pend_next = '0;
                    is_read_next = (dec_op == SEQ_READ);
                    state_next   = (dec_op != SEQ_NONE) ? T_WORK : T_DONE;
                end
            end
            T_WORK:
            begin
                if (seq_sts.done)
                begin
                    rd_pend_next = is_read_reg ? 32'(seq_rdata) : '0;
                    state_next   = T_DONE;
                end
            end
            T_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next  = 1'b1;
                    read_value_next = rd_pend_reg;
                    status_next     = st_pend_reg;
                    count_out_next  = 6'(count_reg);
                    cursor_out_next = 6'(cursor_reg);
                    on_entry_next   = (cursor_reg < count_reg);
                    state_next      = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            count_reg     <= '0;
            cursor_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cursor_reg    <= cursor_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Pending result and response payload.
    always_ff @(posedge clk)
    begin
        st_pend_reg    <= st_pend_next;
        rd_pend_reg    <= rd_pend_next;
        is_read_reg    <= is_read_next;
        read_value_reg <= read_value_next;
        status_reg     <= status_next;
        count_out_reg  <= count_out_next;
        cursor_out_reg <= cursor_out_next;
        on_entry_reg   <= on_entry_next;
    end

    csstore_seq #(
        .CAPACITY_WORDS (CAPACITY_WORDS),
        .WORD_BITS      (WORD_BITS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (seq_ctl),
        .first_addr (seq_first),
        .end_addr   (seq_end),
        .prev_addr  (seq_prev),
        .put_addr   (seq_put),
        .word       (word_ext),
        .sts        (seq_sts),
        .rdata      (seq_rdata)
    );

    assign req_stall       = (state_reg != T_IDLE);
    assign rsp_valid       = rsp_valid_reg;
    assign read_value      = read_value_reg;
    assign status_code     = status_reg;
    assign entry_count     = count_out_reg;
    assign cursor_position = cursor_out_reg;
    assign on_entry        = on_entry_reg;

    // The entry count never passes the capacity.
    `CSS_ASSERT_IMP(a_count_cap, 1'b1, count_reg <= CW'(CAPACITY_WORDS),
        "entry count above capacity")
    // Memory work is only launched while the sequencer is free.
    `CSS_ASSERT_IMP(a_go_when_free, seq_ctl.go, !seq_sts.busy,
        "sequencer launched while busy")
    // The sequencer only finishes while a request waits on it.
    `CSS_ASSERT_IMP(a_done_in_work, seq_sts.done, state_reg == T_WORK,
        "sequencer finished with no request waiting")
    // An accepted request always holds off the next one.
    `CSS_ASSERT_NXT(a_busy_after_accept, req_valid && !req_stall, req_stall,
        "request accepted without stalling the next")

endmodule

### sv/csstore_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module csstore_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/csstore_seq.sv
// Memory sequencer: shifts entries one place a cycle, places new words and reads entries.
`include "cursor_sequence_store_assert.svh"

module csstore_seq #(
    parameter int CAPACITY_WORDS = 32,
    parameter int WORD_BITS      = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  csstore_pkg::seq_ctl_t             ctl,
    input  logic [$clog2(CAPACITY_WORDS)-1:0] first_addr,
    input  logic [$clog2(CAPACITY_WORDS)-1:0] end_addr,
    input  logic [$clog2(CAPACITY_WORDS)-1:0] prev_addr,
    input  logic [$clog2(CAPACITY_WORDS)-1:0] put_addr,
    input  logic [WORD_BITS-1:0]              word,
    output csstore_pkg::seq_sts_t             sts,
    output logic [WORD_BITS-1:0]              rdata
);

    import csstore_pkg::*;

    localparam int AW = $clog2(CAPACITY_WORDS);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SHIFT = 5'b00010,
        S_DRAIN = 5'b00100,
        S_PUT   = 5'b01000,
        S_FIN   = 5'b10000
    } seq_state_t;

    seq_state_t state_reg, state_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] a_reg, a_next;
    logic [AW-1:0] b_reg, b_next;
    logic [AW-1:0] end_reg, end_next;
    logic [AW-1:0] put_reg, put_next;
    logic [WORD_BITS-1:0] word_reg, word_next;
    logic up_reg, up_next;
    logic rv_reg, rv_next;

    logic [AW-1:0] idx_step;
    logic ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [WORD_BITS-1:0] ram_wr_data;
    logic ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic [WORD_BITS-1:0] ram_rd_data;

    // Shared index unit: one step down for an upward shift, one step up for a downward one.
    assign idx_step = idx_reg + (up_reg ? {AW{1'b1}} : AW'(1));

    // Sequencer. The write address trails the read address through a_reg and b_reg,
    // so each entry lands one place along from where it was read, in the shift direction.
    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        end_next    = end_reg;
        put_next    = put_reg;
        word_next   = word_reg;
        up_next     = up_reg;
        rv_next     = rv_reg;
        ram_rd_en   = 1'b0;
        ram_rd_addr = idx_reg;
        ram_wr_en   = 1'b0;
        ram_wr_addr = b_reg;
        ram_wr_data = ram_rd_data;
        case (state_reg)
            S_IDLE:
            begin
                if (ctl.go)
                begin
                    idx_next  = first_addr;
                    a_next    = prev_addr;
                    end_next  = end_addr;
                    put_next  = put_addr;
                    word_next = word;
                    up_next   = (ctl.op == SEQ_UP);
                    rv_next   = 1'b0;
                    case (ctl.op)
                        SEQ_UP:   state_next = ctl.shift ? S_SHIFT : S_PUT;
                        SEQ_DOWN: state_next = ctl.shift ? S_SHIFT : S_FIN;
                        SEQ_READ:
                        begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = first_addr;
                            state_next  = S_FIN;
                        end
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_SHIFT:
            begin
                ram_rd_en = 1'b1;
                ram_wr_en = rv_reg;
                a_next    = idx_reg;
                b_next    = a_reg;
                rv_next   = 1'b1;
                if (idx_reg == end_reg)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    idx_next = idx_step;
                end
            end
            S_DRAIN:
            begin
                ram_wr_en  = 1'b1;
                state_next = up_reg ? S_PUT : S_FIN;
            end
            S_PUT:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = put_reg;
                ram_wr_data = word_reg;
                state_next  = S_FIN;
            end
            S_FIN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rv_reg    <= rv_next;
        end
    end

    // Addresses and the word to place.
    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        end_reg  <= end_next;
        put_reg  <= put_next;
        word_reg <= word_next;
        up_reg   <= up_next;
    end

    csstore_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (CAPACITY_WORDS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign sts.busy = (state_reg != S_IDLE);
    assign sts.done = (state_reg == S_FIN);
    assign rdata    = ram_rd_data;

    // A shift write always carries data read in the cycle before.
    `CSS_ASSERT_IMP(a_shift_write_after_read, state_reg == S_SHIFT && ram_wr_en,
        $past(ram_rd_en), "shift write without a preceding read")
    // Reading and writing in one cycle never touch the same entry.
    `CSS_ASSERT_IMP(a_rw_apart, ram_wr_en && ram_rd_en, ram_wr_addr != ram_rd_addr,
        "read and write collide on one entry")
    // A read finishes in the cycle after it is launched.
    `CSS_ASSERT_NXT(a_read_done, state_reg == S_IDLE && ctl.go && ctl.op == SEQ_READ,
        state_reg == S_FIN, "read did not finish in one cycle")

endmodule
